// ----- sv/rpts_pkg.sv -----
// Shared types, constants and the register setting tables of the radio sequencer.
package rpts_pkg;

    localparam int PAYLOAD_MAX = 16;
    localparam int PAY_AW      = $clog2(PAYLOAD_MAX);

    localparam logic [4:0] LENGTH_RESET = 5'd10;

    // input function codes
    localparam logic [1:0] FUNC_POLL   = 2'd0;
    localparam logic [1:0] FUNC_LOAD   = 2'd1;
    localparam logic [1:0] FUNC_TX_REQ = 2'd2;
    localparam logic [1:0] FUNC_RX_REQ = 2'd3;

    // transmit steps
    localparam logic [2:0] TX_STEP_START = 3'd0;
    localparam logic [2:0] TX_STEP_SETUP = 3'd1;
    localparam logic [2:0] TX_STEP_FILL  = 3'd2;
    localparam logic [2:0] TX_STEP_GO    = 3'd3;
    localparam logic [2:0] TX_STEP_POLL  = 3'd4;
    localparam logic [2:0] TX_STEP_WAIT  = 3'd5;
    localparam logic [2:0] TX_STEP_DONE  = 3'd6;

    // receive steps
    localparam logic [2:0] RX_STEP_START = 3'd0;
    localparam logic [2:0] RX_STEP_SETUP = 3'd1;
    localparam logic [2:0] RX_STEP_POLL  = 3'd2;
    localparam logic [2:0] RX_STEP_WAIT  = 3'd3;
    localparam logic [2:0] RX_STEP_READ  = 3'd4;
    localparam logic [2:0] RX_STEP_STORE = 3'd5;
    localparam logic [2:0] RX_STEP_DONE  = 3'd6;

    // radio register bytes
    localparam logic [7:0] REG_IRQ_FLAGS = 8'h12;
    localparam logic [7:0] REG_FIFO_WR   = 8'h80;
    localparam logic [7:0] REG_FIFO_RD   = 8'h00;
    localparam logic [7:0] OPMODE_WR     = 8'h81;
    localparam logic [7:0] OPMODE_TX     = 8'h83;
    localparam logic [7:0] DUMMY_BYTE    = 8'h00;
    localparam int         IRQ_TX_BIT    = 3;
    localparam int         IRQ_RX_BIT    = 6;

    localparam logic [4:0] TX_SETUP_BYTES = 5'd8;
    localparam logic [4:0] RX_SETUP_BYTES = 5'd10;

    localparam logic [1:0] ANT_NONE = 2'd0;
    localparam logic [1:0] ANT_TX   = 2'd1;
    localparam logic [1:0] ANT_RX   = 2'd2;

    typedef struct packed {
        logic [2:0] tx_step;
        logic [2:0] rx_step;
        logic       tx_pending;
        logic       rx_pending;
        logic [4:0] remaining_count;
        logic [4:0] table_position;
        logic [7:0] held_addr_byte;
        logic [7:0] held_data_byte;
        logic [1:0] antenna_state;
    } seq_state_t;

    typedef struct packed {
        logic       spi_start;
        logic [7:0] spi_addr_byte;
        logic [7:0] spi_data_byte;
        logic       rx_byte_valid;
        logic [7:0] rx_byte;
        logic [3:0] rx_byte_index;
        logic       tx_done;
        logic       rx_done;
        logic       led_toggle;
        logic [1:0] antenna;
        logic       tx_busy;
        logic       rx_busy;
    } seq_result_t;

    // Setting pair {addr, data}; a pair index past the table uses the last pair.
    function automatic logic [15:0] setting_pair(input logic is_rx, input logic [3:0] pair_idx);
        logic [2:0]  p;
        logic [15:0] pair;
        if (is_rx)
            p = (pair_idx >= 4'd5) ? 3'd4 : pair_idx[2:0];
        else
            p = (pair_idx >= 4'd4) ? 3'd3 : pair_idx[2:0];
        case (p)
            3'd0:    pair = 16'h8181;
            3'd1:    pair = 16'h8d00;
            3'd2:    pair = is_rx ? 16'ha500 : 16'h8e00;
            3'd3:    pair = 16'h92ff;
            default: pair = 16'h8185;
        endcase
        return pair;
    endfunction

endpackage

// ----- sv/rpts_step.sv -----
// Next-state and result logic for one sequencer transaction.
module rpts_step (
    input  rpts_pkg::seq_state_t  st,
    input  logic [1:0]            func,
    input  logic                  spi_busy,
    input  logic [7:0]            spi_read_byte,
    input  logic [7:0]            pay_rd_byte,
    input  logic [4:0]            payload_length,
    output rpts_pkg::seq_state_t  nxt,
    output rpts_pkg::seq_result_t res
);
    import rpts_pkg::*;

    logic [4:0]  eff_len;
    logic [15:0] pair;
    logic [4:0]  rem_less2;
    logic [4:0]  rem_less1;

    always_comb
    begin
        if (payload_length == 5'd0)
            eff_len = 5'd1;
        else if (payload_length > 5'(PAYLOAD_MAX))
            eff_len = 5'(PAYLOAD_MAX);
        else
            eff_len = payload_length;
    end

    assign pair      = setting_pair(!st.tx_pending, st.table_position[4:1]);
    assign rem_less2 = (st.remaining_count > 5'd2) ? st.remaining_count - 5'd2 : 5'd0;
    assign rem_less1 = (st.remaining_count > 5'd1) ? st.remaining_count - 5'd1 : 5'd0;

    always_comb
    begin
        nxt = st;
        res = '0;
        unique case (func)
            FUNC_LOAD:
            begin
                // payload memory write is done in the top level
            end
            FUNC_TX_REQ:
            begin
                nxt.tx_pending = 1'b1;
                nxt.tx_step    = TX_STEP_START;
            end
            FUNC_RX_REQ:
            begin
                nxt.rx_pending = 1'b1;
                nxt.rx_step    = RX_STEP_START;
            end
            default:
            begin
                if (!spi_busy && st.tx_pending)
                begin
                    unique case (st.tx_step)
                        TX_STEP_START:
                        begin
                            res.led_toggle      = 1'b1;
                            nxt.antenna_state   = ANT_TX;
                            nxt.remaining_count = TX_SETUP_BYTES;
                            nxt.table_position  = '0;
                            nxt.tx_step         = TX_STEP_SETUP;
                        end
                        TX_STEP_SETUP:
                        begin
                            res.spi_start       = 1'b1;
                            res.spi_addr_byte   = pair[15:8];
                            res.spi_data_byte   = pair[7:0];
                            nxt.held_addr_byte  = pair[15:8];
                            nxt.held_data_byte  = pair[7:0];
                            nxt.table_position  = st.table_position + 5'd2;
                            nxt.remaining_count = rem_less2;
                            if (rem_less2 == 5'd0)
                            begin
                                nxt.remaining_count = eff_len;
                                nxt.table_position  = '0;
                                nxt.held_addr_byte  = REG_FIFO_WR;
                                nxt.tx_step         = TX_STEP_FILL;
                            end
                        end
                        TX_STEP_FILL:
                        begin
                            res.spi_start       = 1'b1;
                            res.spi_addr_byte   = st.held_addr_byte;
                            res.spi_data_byte   = pay_rd_byte;
                            nxt.held_data_byte  = pay_rd_byte;
                            nxt.table_position  = st.table_position + 5'd1;
                            nxt.remaining_count = rem_less1;
                            if (rem_less1 == 5'd0)
                                nxt.tx_step = TX_STEP_GO;
                        end
                        TX_STEP_GO:
                        begin
                            res.spi_start      = 1'b1;
                            res.spi_addr_byte  = OPMODE_WR;
                            res.spi_data_byte  = OPMODE_TX;
                            nxt.held_addr_byte = OPMODE_WR;
                            nxt.held_data_byte = OPMODE_TX;
                            nxt.tx_step        = TX_STEP_POLL;
                        end
                        TX_STEP_POLL:
                        begin
                            res.spi_start      = 1'b1;
                            res.spi_addr_byte  = REG_IRQ_FLAGS;
                            res.spi_data_byte  = DUMMY_BYTE;
                            nxt.held_addr_byte = REG_IRQ_FLAGS;
                            nxt.held_data_byte = DUMMY_BYTE;
                            nxt.tx_step        = TX_STEP_WAIT;
                        end
                        TX_STEP_WAIT:
                        begin
                            if (!spi_read_byte[IRQ_TX_BIT])
                                nxt.tx_step = TX_STEP_POLL;
                            else
                            begin
                                res.tx_done    = 1'b1;
                                nxt.tx_pending = 1'b0;
                                nxt.tx_step    = TX_STEP_DONE;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
                else if (!spi_busy && st.rx_pending)
                begin
                    unique case (st.rx_step)
                        RX_STEP_START:
                        begin
                            res.led_toggle      = 1'b1;
                            nxt.antenna_state   = ANT_RX;
                            nxt.remaining_count = RX_SETUP_BYTES;
                            nxt.table_position  = '0;
                            nxt.rx_step         = RX_STEP_SETUP;
                        end
                        RX_STEP_SETUP:
                        begin
                            res.spi_start       = 1'b1;
                            res.spi_addr_byte   = pair[15:8];
                            res.spi_data_byte   = pair[7:0];
                            nxt.held_addr_byte  = pair[15:8];
                            nxt.held_data_byte  = pair[7:0];
                            nxt.table_position  = st.table_position + 5'd2;
                            nxt.remaining_count = rem_less2;
                            if (rem_less2 == 5'd0)
                                nxt.rx_step = RX_STEP_POLL;
                        end
                        RX_STEP_POLL:
                        begin
                            res.spi_start      = 1'b1;
                            res.spi_addr_byte  = REG_IRQ_FLAGS;
                            res.spi_data_byte  = DUMMY_BYTE;
                            nxt.held_addr_byte = REG_IRQ_FLAGS;
                            nxt.held_data_byte = DUMMY_BYTE;
                            nxt.rx_step        = RX_STEP_WAIT;
                        end
                        RX_STEP_WAIT:
                        begin
                            if (!spi_read_byte[IRQ_RX_BIT])
                                nxt.rx_step = RX_STEP_POLL;
                            else
                            begin
                                nxt.remaining_count = eff_len;
                                nxt.table_position  = '0;
                                nxt.held_addr_byte  = REG_FIFO_RD;
                                nxt.rx_step         = RX_STEP_READ;
                            end
                        end
                        RX_STEP_READ:
                        begin
                            // reuses whatever data byte was last sent as the dummy
                            res.spi_start     = 1'b1;
                            res.spi_addr_byte = st.held_addr_byte;
                            res.spi_data_byte = st.held_data_byte;
                            nxt.rx_step       = RX_STEP_STORE;
                        end
                        RX_STEP_STORE:
                        begin
                            res.rx_byte_valid   = 1'b1;
                            res.rx_byte         = spi_read_byte;
                            res.rx_byte_index   = st.table_position[3:0];
                            nxt.table_position  = st.table_position + 5'd1;
                            nxt.remaining_count = rem_less1;
                            if (rem_less1 == 5'd0)
                            begin
                                res.rx_done    = 1'b1;
                                nxt.rx_pending = 1'b0;
                                nxt.rx_step    = RX_STEP_DONE;
                            end
                            else
                                nxt.rx_step = RX_STEP_READ;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
        endcase
        res.antenna = nxt.antenna_state;
        res.tx_busy = nxt.tx_pending;
        res.rx_busy = nxt.rx_pending;
    end

endmodule

// ----- sv/radio_packet_tx_rx_sequencer_unit.sv -----
// Top level of the packet radio transmit/receive sequencer.
//
//  channel   handshake              payload
//  ------    ---------------------  ------------------------------------------------
//  input     in_valid / in_ready    func, spi_busy, spi_read_byte, payload_index/byte
//  output    out_valid / out_ready  spi_*, rx_byte*, tx/rx_done, led_toggle, antenna,
//                                   tx_busy, rx_busy
//  config    cfg_we                 cfg_wdata (payload_length)
//
// In every transaction the sequencer state and the payload store update at the accepting
// edge and the result lands in the output register.
// A new transaction is taken each cycle while the output register is empty or drained.
// Reset clears the step counters, pending flags and counters; payload_length resets to 10.
// The payload store has no reset. A stalled output holds the input off.
module radio_packet_tx_rx_sequencer_unit (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] func,
    input  logic       spi_busy,
    input  logic [7:0] spi_read_byte,
    input  logic [3:0] payload_index,
    input  logic [7:0] payload_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       spi_start,
    output logic [7:0] spi_addr_byte,
    output logic [7:0] spi_data_byte,
    output logic       rx_byte_valid,
    output logic [7:0] rx_byte,
    output logic [3:0] rx_byte_index,
    output logic       tx_done,
    output logic       rx_done,
    output logic       led_toggle,
    output logic [1:0] antenna,
    output logic       tx_busy,
    output logic       rx_busy,
    input  logic       cfg_we,
    input  logic [4:0] cfg_wdata
);
    import rpts_pkg::*;

    seq_state_t  st_reg;
    seq_state_t  st_next;
    seq_result_t res_next;
    seq_result_t out_reg;
    logic        out_valid_reg;
    logic [4:0]  length_reg;
    logic [7:0]  pay_mem [PAYLOAD_MAX];
    logic [7:0]  pay_rd_byte;
    logic        in_accept;

    assign in_ready    = !out_valid_reg || out_ready;
    assign in_accept   = in_valid && in_ready;
    assign pay_rd_byte = pay_mem[st_reg.table_position[PAY_AW-1:0]];

    rpts_step u_step (
        .st             (st_reg),
        .func           (func),
        .spi_busy       (spi_busy),
        .spi_read_byte  (spi_read_byte),
        .pay_rd_byte    (pay_rd_byte),
        .payload_length (length_reg),
        .nxt            (st_next),
        .res            (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            length_reg <= LENGTH_RESET;
        else if (cfg_we)
            length_reg <= cfg_wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_accept)
                st_reg <= st_next;
            if (in_accept)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
            out_reg <= res_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_accept && func == FUNC_LOAD)
            pay_mem[payload_index[PAY_AW-1:0]] <= payload_byte;
    end

    assign out_valid     = out_valid_reg;
    assign spi_start     = out_reg.spi_start;
    assign spi_addr_byte = out_reg.spi_addr_byte;
    assign spi_data_byte = out_reg.spi_data_byte;
    assign rx_byte_valid = out_reg.rx_byte_valid;
    assign rx_byte       = out_reg.rx_byte;
    assign rx_byte_index = out_reg.rx_byte_index;
    assign tx_done       = out_reg.tx_done;
    assign rx_done       = out_reg.rx_done;
    assign led_toggle    = out_reg.led_toggle;
    assign antenna       = out_reg.antenna;
    assign tx_busy       = out_reg.tx_busy;
    assign rx_busy       = out_reg.rx_busy;

    // a load transaction never issues a register access
    a_load_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept && func == FUNC_LOAD |=> out_valid_reg && !out_reg.spi_start)
        else $error("load transaction issued a register access");

    // busy flags in the result track the pending state the transaction left behind
    a_busy_track: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> out_reg.tx_busy == st_reg.tx_pending && out_reg.rx_busy == st_reg.rx_pending)
        else $error("busy flags out of step with pending state");

    // a delivered receive byte and a register access never share a result
    a_rx_no_access: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.rx_byte_valid |-> !out_reg.spi_start && !out_reg.tx_done)
        else $error("receive byte delivered together with an access");

    // step counters never leave their defined range
    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        st_reg.tx_step <= TX_STEP_DONE && st_reg.rx_step <= RX_STEP_DONE)
        else $error("step counter out of range");

    // a transmit request restarts the transmit task
    a_tx_restart: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept && func == FUNC_TX_REQ |=> st_reg.tx_pending && st_reg.tx_step == TX_STEP_START)
        else $error("transmit request did not restart the task");

endmodule

// ----- tb/sv/tb_radio_packet_tx_rx_sequencer_unit.sv -----
// Self-checking testbench for the radio packet transmit/receive sequencer.
module tb_radio_packet_tx_rx_sequencer_unit;
    timeunit 1ns;
    timeprecision 1ps;
    import rpts_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 8;
    localparam int PHASE_ITEMS  = 115;

    // setting bytes not named in the package
    localparam logic [7:0] OPMODE_STDBY     = 8'h81;
    localparam logic [7:0] OPMODE_RX        = 8'h85;
    localparam logic [7:0] REG_FIFO_PTR_WR  = 8'h8d;
    localparam logic [7:0] REG_TX_BASE_WR   = 8'h8e;
    localparam logic [7:0] REG_RX_BASE_WR   = 8'ha5;
    localparam logic [7:0] REG_IRQ_CLR_WR   = 8'h92;
    localparam logic [7:0] IRQ_CLEAR_ALL    = 8'hff;
    localparam logic [7:0] FIFO_BASE        = 8'h00;

    typedef struct packed {
        logic [1:0] func;
        logic       busy;
        logic [7:0] rd;
        logic [3:0] idx;
        logic [7:0] pb;
    } radio_cmd_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic [1:0] func = FUNC_POLL;
    logic       spi_busy = 1'b0;
    logic [7:0] spi_read_byte = 8'h00;
    logic [3:0] payload_index = 4'h0;
    logic [7:0] payload_byte = 8'h00;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic       spi_start;
    logic [7:0] spi_addr_byte;
    logic [7:0] spi_data_byte;
    logic       rx_byte_valid;
    logic [7:0] rx_byte;
    logic [3:0] rx_byte_index;
    logic       tx_done;
    logic       rx_done;
    logic       led_toggle;
    logic [1:0] antenna;
    logic       tx_busy;
    logic       rx_busy;
    logic       cfg_we = 1'b0;
    logic [4:0] cfg_wdata = 5'd0;

    radio_cmd_t  cmd_queue[$];
    seq_result_t expected_results[$];
    radio_cmd_t  live_cmd;

    // sequencer image kept by the testbench
    logic [4:0]  len_setting;
    logic [2:0]  tx_phase;
    logic [2:0]  rx_phase;
    bit          tx_wanted;
    bit          rx_wanted;
    int          remain_cnt;
    int          table_pos;
    logic [7:0]  last_addr;
    logic [7:0]  last_data;
    logic [7:0]  tx_bytes [0:PAYLOAD_MAX-1];
    logic [1:0]  ant_sel;
    seq_result_t pred;

    int cycle_count = 0;
    int fail_count = 0;
    int accepted_count = 0;
    int result_count = 0;
    int tx_done_seen = 0;
    int rx_done_seen = 0;
    int queued_items = 0;
    int settings_used = 1;
    int burst_left = 0;
    int gap_left = 0;
    int pattern_age = 0;
    logic [31:0] ready_pattern = '1;

    radio_packet_tx_rx_sequencer_unit u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .func          (func),
        .spi_busy      (spi_busy),
        .spi_read_byte (spi_read_byte),
        .payload_index (payload_index),
        .payload_byte  (payload_byte),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .spi_start     (spi_start),
        .spi_addr_byte (spi_addr_byte),
        .spi_data_byte (spi_data_byte),
        .rx_byte_valid (rx_byte_valid),
        .rx_byte       (rx_byte),
        .rx_byte_index (rx_byte_index),
        .tx_done       (tx_done),
        .rx_done       (rx_done),
        .led_toggle    (led_toggle),
        .antenna       (antenna),
        .tx_busy       (tx_busy),
        .rx_busy       (rx_busy),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ---------------- sequencer prediction ----------------

    function automatic void clear_sequencer();
        len_setting = LENGTH_RESET;
        tx_phase    = TX_STEP_START;
        rx_phase    = RX_STEP_START;
        tx_wanted   = 1'b0;
        rx_wanted   = 1'b0;
        remain_cnt  = 0;
        table_pos   = 0;
        last_addr   = 8'h00;
        last_data   = 8'h00;
        ant_sel     = ANT_NONE;
        for (int i = 0; i < PAYLOAD_MAX; i++)
            tx_bytes[i] = 8'h00;
    endfunction

    function automatic int clamped_length();
        if (len_setting == 5'd0)
            return 1;
        if (int'(len_setting) > PAYLOAD_MAX)
            return PAYLOAD_MAX;
        return int'(len_setting);
    endfunction

    function automatic int count_down(input int v, input int k);
        return (v > k) ? v - k : 0;
    endfunction

    function automatic void send_access(input logic [7:0] a, input logic [7:0] d);
        last_addr = a;
        last_data = d;
        pred.spi_start     = 1'b1;
        pred.spi_addr_byte = a;
        pred.spi_data_byte = d;
    endfunction

    // {addr, data} of a setup pair; positions past the end reuse the last pair
    function automatic logic [15:0] setup_entry(input bit for_rx, input int pair);
        int p;
        p = pair;
        if (for_rx && p > 4)
            p = 4;
        if (!for_rx && p > 3)
            p = 3;
        case (p)
            0:       return {OPMODE_WR, OPMODE_STDBY};
            1:       return {REG_FIFO_PTR_WR, FIFO_BASE};
            2:       return for_rx ? {REG_RX_BASE_WR, FIFO_BASE} : {REG_TX_BASE_WR, FIFO_BASE};
            3:       return {REG_IRQ_CLR_WR, IRQ_CLEAR_ALL};
            default: return {OPMODE_WR, OPMODE_RX};
        endcase
    endfunction

    function automatic bit setup_step(input bit for_rx);
        logic [15:0] pr;
        pr = setup_entry(for_rx, table_pos >> 1);
        send_access(pr[15:8], pr[7:0]);
        table_pos  = table_pos + 2;
        remain_cnt = count_down(remain_cnt, 2);
        return remain_cnt == 0;
    endfunction

    function automatic void tx_advance();
        case (tx_phase)
            TX_STEP_START:
            begin
                pred.led_toggle = 1'b1;
                ant_sel    = ANT_TX;
                remain_cnt = int'(TX_SETUP_BYTES);
                table_pos  = 0;
                tx_phase   = TX_STEP_SETUP;
            end
            TX_STEP_SETUP:
            begin
                if (setup_step(1'b0))
                begin
                    remain_cnt = clamped_length();
                    table_pos  = 0;
                    last_addr  = REG_FIFO_WR;
                    tx_phase   = TX_STEP_FILL;
                end
            end
            TX_STEP_FILL:
            begin
                send_access(last_addr, tx_bytes[table_pos % PAYLOAD_MAX]);
                table_pos  = table_pos + 1;
                remain_cnt = count_down(remain_cnt, 1);
                if (remain_cnt == 0)
                    tx_phase = TX_STEP_GO;
            end
            TX_STEP_GO:
            begin
                send_access(OPMODE_WR, OPMODE_TX);
                tx_phase = TX_STEP_POLL;
            end
            TX_STEP_POLL:
            begin
                send_access(REG_IRQ_FLAGS, DUMMY_BYTE);
                tx_phase = TX_STEP_WAIT;
            end
            default:
            begin
            end
        endcase
    endfunction

    function automatic void rx_advance(input logic [7:0] rd);
        case (rx_phase)
            RX_STEP_START:
            begin
                pred.led_toggle = 1'b1;
                ant_sel    = ANT_RX;
                remain_cnt = int'(RX_SETUP_BYTES);
                table_pos  = 0;
                rx_phase   = RX_STEP_SETUP;
            end
            RX_STEP_SETUP:
            begin
                if (setup_step(1'b1))
                    rx_phase = RX_STEP_POLL;
            end
            RX_STEP_POLL:
            begin
                send_access(REG_IRQ_FLAGS, DUMMY_BYTE);
                rx_phase = RX_STEP_WAIT;
            end
            RX_STEP_WAIT:
            begin
                if (!rd[IRQ_RX_BIT])
                    rx_phase = RX_STEP_POLL;
                else
                begin
                    remain_cnt = clamped_length();
                    table_pos  = 0;
                    last_addr  = REG_FIFO_RD;
                    rx_phase   = RX_STEP_READ;
                end
            end
            // address is the FIFO read register or the last access's; data is whatever the last access left behind
            RX_STEP_READ:
            begin
                send_access(last_addr, last_data);
                rx_phase = RX_STEP_STORE;
            end
            RX_STEP_STORE:
            begin
                pred.rx_byte_valid = 1'b1;
                pred.rx_byte       = rd;
                pred.rx_byte_index = table_pos[3:0];
                table_pos  = table_pos + 1;
                remain_cnt = count_down(remain_cnt, 1);
                if (remain_cnt == 0)
                begin
                    pred.rx_done = 1'b1;
                    rx_wanted    = 1'b0;
                    rx_phase     = RX_STEP_DONE;
                end
                else
                    rx_phase = RX_STEP_READ;
            end
            default:
            begin
            end
        endcase
    endfunction

    function automatic seq_result_t sequencer_step(input radio_cmd_t c);
        pred = '0;
        case (c.func)
            FUNC_LOAD:
                tx_bytes[c.idx] = c.pb;
            FUNC_TX_REQ:
            begin
                tx_wanted = 1'b1;
                tx_phase  = TX_STEP_START;
            end
            FUNC_RX_REQ:
            begin
                rx_wanted = 1'b1;
                rx_phase  = RX_STEP_START;
            end
            default:
            begin
                if (!c.busy)
                begin
                    if (tx_wanted)
                    begin
                        if (tx_phase == TX_STEP_WAIT)
                        begin
                            if (!c.rd[IRQ_TX_BIT])
                                tx_phase = TX_STEP_POLL;
                            else
                            begin
                                pred.tx_done = 1'b1;
                                tx_wanted    = 1'b0;
                                tx_phase     = TX_STEP_DONE;
                            end
                        end
                        else
                            tx_advance();
                    end
                    else if (rx_wanted)
                        rx_advance(c.rd);
                end
            end
        endcase
        pred.antenna = ant_sel;
        pred.tx_busy = tx_wanted;
        pred.rx_busy = rx_wanted;
        return pred;
    endfunction

    // ---------------- stimulus ----------------

    function automatic void push_cmd(input logic [1:0] f, input logic busy, input logic [7:0] rd,
                                     input logic [3:0] idx, input logic [7:0] pb);
        radio_cmd_t c;
        c.func = f;
        c.busy = busy;
        c.rd   = rd;
        c.idx  = idx;
        c.pb   = pb;
        cmd_queue.push_back(c);
        queued_items++;
    endfunction

    function automatic void push_poll(input logic [7:0] rd);
        push_cmd(FUNC_POLL, $urandom_range(0, 5) == 0, rd, 4'($urandom), 8'($urandom));
    endfunction

    function automatic void maybe_interject(input int odds);
        if ($urandom_range(1, odds) == 1)
            push_cmd(2'($urandom_range(FUNC_LOAD, FUNC_RX_REQ)), 1'($urandom), 8'($urandom),
                     4'($urandom), 8'($urandom));
    endfunction

    task automatic queue_transmit(input int len);
        logic [7:0] rd;
        int n;
        push_cmd(FUNC_TX_REQ, 1'($urandom), 8'($urandom), 4'($urandom), 8'($urandom));
        n = len + 7 + $urandom_range(0, 4);
        repeat (n)
        begin
            rd = 8'($urandom);
            rd[IRQ_TX_BIT] = 1'b0;
            push_poll(rd);
            maybe_interject(30);
        end
        n = $urandom_range(0, 6);
        repeat (n)
            push_poll(8'($urandom));
        rd = 8'($urandom);
        rd[IRQ_TX_BIT] = 1'b1;
        push_cmd(FUNC_POLL, 1'b0, rd, 4'($urandom), 8'($urandom));
    endtask

    task automatic queue_receive(input int len);
        logic [7:0] rd;
        int n;
        push_cmd(FUNC_RX_REQ, 1'($urandom), 8'($urandom), 4'($urandom), 8'($urandom));
        n = 6 + $urandom_range(0, 2);
        repeat (n)
            push_poll(8'($urandom));
        // irq wait loop, flag raised now and then, then for sure
        n = $urandom_range(0, 6);
        repeat (n)
        begin
            push_poll(8'($urandom));
            rd = 8'($urandom);
            rd[IRQ_RX_BIT] = ($urandom_range(0, 2) == 0);
            push_poll(rd);
        end
        rd = 8'($urandom);
        rd[IRQ_RX_BIT] = 1'b1;
        push_poll(8'($urandom));
        push_poll(rd);
        n = 2 * len + $urandom_range(0, 4);
        repeat (n)
        begin
            push_poll(8'($urandom));
            maybe_interject(40);
        end
    endtask

    task automatic queue_traffic(input int budget);
        int start;
        int len;
        start = queued_items;
        len   = clamped_length();
        while (queued_items - start < budget)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: queue_transmit(len);
                4, 5, 6, 7: queue_receive(len);
                default:
                begin
                    repeat ($urandom_range(1, 6))
                        push_cmd(2'($urandom), 1'($urandom), 8'($urandom), 4'($urandom),
                                 8'($urandom));
                end
            endcase
        end
    endtask

    task automatic wait_for_drain();
        while (cmd_queue.size() != 0 || in_valid || expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic void note_failure(input string msg);
        fail_count++;
        if (fail_count <= 10)
            $display("ERROR: %s", msg);
    endfunction

    function automatic string field_diffs(input seq_result_t want, input seq_result_t got);
        string s;
        s = "";
        if (want.spi_start != got.spi_start)
            s = {s, $sformatf(" spi_start exp %0h got %0h", want.spi_start, got.spi_start)};
        if (want.spi_addr_byte != got.spi_addr_byte)
            s = {s, $sformatf(" spi_addr_byte exp %02h got %02h", want.spi_addr_byte,
                              got.spi_addr_byte)};
        if (want.spi_data_byte != got.spi_data_byte)
            s = {s, $sformatf(" spi_data_byte exp %02h got %02h", want.spi_data_byte,
                              got.spi_data_byte)};
        if (want.rx_byte_valid != got.rx_byte_valid)
            s = {s, $sformatf(" rx_byte_valid exp %0h got %0h", want.rx_byte_valid,
                              got.rx_byte_valid)};
        if (want.rx_byte != got.rx_byte)
            s = {s, $sformatf(" rx_byte exp %02h got %02h", want.rx_byte, got.rx_byte)};
        if (want.rx_byte_index != got.rx_byte_index)
            s = {s, $sformatf(" rx_byte_index exp %0d got %0d", want.rx_byte_index,
                              got.rx_byte_index)};
        if (want.tx_done != got.tx_done)
            s = {s, $sformatf(" tx_done exp %0h got %0h", want.tx_done, got.tx_done)};
        if (want.rx_done != got.rx_done)
            s = {s, $sformatf(" rx_done exp %0h got %0h", want.rx_done, got.rx_done)};
        if (want.led_toggle != got.led_toggle)
            s = {s, $sformatf(" led_toggle exp %0h got %0h", want.led_toggle, got.led_toggle)};
        if (want.antenna != got.antenna)
            s = {s, $sformatf(" antenna exp %0d got %0d", want.antenna, got.antenna)};
        if (want.tx_busy != got.tx_busy)
            s = {s, $sformatf(" tx_busy exp %0h got %0h", want.tx_busy, got.tx_busy)};
        if (want.rx_busy != got.rx_busy)
            s = {s, $sformatf(" rx_busy exp %0h got %0h", want.rx_busy, got.rx_busy)};
        return s;
    endfunction

    // ---------------- driver ----------------

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid  <= 1'b0;
            burst_left = 0;
            gap_left   = 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                expected_results.push_back(sequencer_step(live_cmd));
                accepted_count++;
            end
            if (!in_valid || in_ready)
            begin
                if (gap_left > 0 || cmd_queue.size() == 0)
                begin
                    if (gap_left > 0)
                        gap_left--;
                    in_valid <= 1'b0;
                end
                else
                begin
                    live_cmd = cmd_queue.pop_front();
                    in_valid      <= 1'b1;
                    func          <= live_cmd.func;
                    spi_busy      <= live_cmd.busy;
                    spi_read_byte <= live_cmd.rd;
                    payload_index <= live_cmd.idx;
                    payload_byte  <= live_cmd.pb;
                    if (burst_left > 0)
                        burst_left--;
                    if (burst_left == 0)
                    begin
                        burst_left = $urandom_range(1, 48);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
                    end
                end
            end
        end
    end

    // ---------------- receiver stalls ----------------

    always @(posedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (pattern_age == 0)
            begin
                pattern_age = $urandom_range(16, 96);
                case ($urandom_range(0, 2))
                    0:       ready_pattern = '1;
                    1:       ready_pattern = $urandom | $urandom;
                    default: ready_pattern = $urandom;
                endcase
            end
            pattern_age--;
            ready_pattern = {ready_pattern[0], ready_pattern[31:1]};
            out_ready <= ready_pattern[0];
        end
    end

    // ---------------- monitor ----------------

    always @(posedge clk)
    begin
        seq_result_t observed;
        seq_result_t want;
        string diffs;
        if (rst_n && out_valid && out_ready)
        begin
            observed = {spi_start, spi_addr_byte, spi_data_byte, rx_byte_valid, rx_byte,
                        rx_byte_index, tx_done, rx_done, led_toggle, antenna, tx_busy, rx_busy};
            if (expected_results.size() == 0)
                note_failure($sformatf("result %0d arrived with nothing expected", result_count));
            else
            begin
                want  = expected_results.pop_front();
                diffs = field_diffs(want, observed);
                if (diffs != "")
                    note_failure($sformatf("result %0d mismatch:%s", result_count, diffs));
            end
            if (observed.tx_done)
                tx_done_seen++;
            if (observed.rx_done)
                rx_done_seen++;
            result_count++;
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
                     expected_results.size());
            $display("FAILED: results differ");
            $finish;
        end
    end

    // ---------------- test sequence ----------------

    initial
    begin
        logic [4:0] len_plan [0:6];
        len_plan[0] = 5'd1;
        len_plan[1] = 5'd16;
        len_plan[2] = 5'd0;
        len_plan[3] = 5'd31;
        len_plan[4] = 5'd17;
        len_plan[5] = 5'($urandom_range(2, 15));
        len_plan[6] = 5'($urandom_range(2, 15));

        clear_sequencer();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // directed: field extremes, every function, busy poll, priority, restart
        push_cmd(FUNC_LOAD, 1'b0, 8'h00, 4'd0, 8'hff);
        push_cmd(FUNC_LOAD, 1'b1, 8'hff, 4'd15, 8'h00);
        push_cmd(FUNC_RX_REQ, 1'b0, 8'h00, 4'd0, 8'h00);
        push_cmd(FUNC_POLL, 1'b1, 8'hff, 4'd15, 8'hff);
        push_cmd(FUNC_POLL, 1'b0, 8'hff, 4'd0, 8'h00);
        push_cmd(FUNC_POLL, 1'b0, 8'h00, 4'd15, 8'hff);
        push_cmd(FUNC_TX_REQ, 1'b1, 8'hff, 4'd15, 8'hff);
        push_cmd(FUNC_POLL, 1'b0, 8'h00, 4'd0, 8'h00);
        push_cmd(FUNC_POLL, 1'b1, 8'h00, 4'd0, 8'h00);
        push_cmd(FUNC_POLL, 1'b0, 8'hff, 4'd0, 8'h00);
        push_cmd(FUNC_TX_REQ, 1'b0, 8'h00, 4'd0, 8'h00);
        push_cmd(FUNC_POLL, 1'b0, 8'h08, 4'd0, 8'h00);
        push_cmd(FUNC_POLL, 1'b0, 8'h40, 4'd0, 8'h00);

        // fill the whole payload store before anything can transmit from it
        for (int i = 0; i < PAYLOAD_MAX; i++)
            push_cmd(FUNC_LOAD, 1'($urandom), 8'($urandom), 4'(i), 8'($urandom));
        queue_traffic(PHASE_ITEMS);
        wait_for_drain();

        for (int ph = 0; ph < 7; ph++)
        begin
            @(posedge clk);
            cfg_we    <= 1'b1;
            cfg_wdata <= len_plan[ph];
            len_setting = len_plan[ph];
            @(posedge clk);
            cfg_we <= 1'b0;
            settings_used++;
            queue_traffic(PHASE_ITEMS);
            wait_for_drain();
        end

        if (expected_results.size() != 0)
            note_failure($sformatf("%0d expected results never arrived",
                                   expected_results.size()));
        $display("run covered %0d transactions over %0d length settings, %0d results checked",
                 accepted_count, settings_used, result_count);
        $display("%0d transmits and %0d receives completed, %0d errors", tx_done_seen,
                 rx_done_seen, fail_count);
        if (fail_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

// ----- filelist.f -----
sv/rpts_pkg.sv
sv/rpts_step.sv
sv/radio_packet_tx_rx_sequencer_unit.sv
tb/sv/tb_radio_packet_tx_rx_sequencer_unit.sv
